FILE: sv/tsp_pkg.sv
// Shared types and constants of the two-stream timestamp pairer.
package tsp_pkg;

  // Port widths of the stream and configuration channels.
  localparam int IN_DATA_W   = 56;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 32;
  localparam int OUT_USER_W  = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  // Input beat layout.
  localparam int STAMP_W   = 32;
  localparam int IN_TAG_W  = 16;
  localparam int OUT_TAG_W = 16;

  // Results per input beat are capped; later ones are dropped.
  localparam int MAX_RESULTS  = 17;
  localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_TOLERANCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_QUEUE_LIMIT    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REQUIRE_MATCH  = 2'd3;

  // Register reset values and clamp bounds.
  localparam logic [19:0] TOL_RESET  = 20'd80000;
  localparam logic [19:0] TOL_MIN    = 20'd5000;
  localparam logic [19:0] TOL_MAX    = 20'd1000000;
  localparam logic [9:0]  HOLD_RESET = 10'd100;
  localparam logic [9:0]  HOLD_MIN   = 10'd1;
  localparam logic [9:0]  HOLD_MAX   = 10'd1000;
  localparam logic [4:0]  QLIM_RESET = 5'd10;
  localparam logic [4:0]  QLIM_MIN   = 5'd2;

  // Result kinds.
  localparam logic [2:0] KIND_PAIR        = 3'd0;
  localparam logic [2:0] KIND_PRI_OLDER   = 3'd1;
  localparam logic [2:0] KIND_SEC_OLDER   = 3'd2;
  localparam logic [2:0] KIND_PRI_TIMEOUT = 3'd3;
  localparam logic [2:0] KIND_SEC_TIMEOUT = 3'd4;
  localparam logic [2:0] KIND_PRI_EVICT   = 3'd5;
  localparam logic [2:0] KIND_SEC_EVICT   = 3'd6;
  localparam logic [2:0] KIND_REJECT      = 3'd7;

  // Operations the controller asks of the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_ITEM,
    OP_TICK,
    OP_REJECT,
    OP_TAKE,
    OP_EVICT,
    OP_APPEND,
    OP_MATCH,
    OP_TIMEOUT,
    OP_FINISH
  } tsp_op_t;

  typedef struct packed {
    tsp_op_t op;
    logic    side;
  } tsp_cmd_t;

  typedef struct packed {
    logic       is_tick;
    logic       rejected;
    logic       evict_due;
    logic       both_nz;
    logic [1:0] aged;
    logic       emit_ok;
  } tsp_status_t;

endpackage

FILE: sv/tsp_ram.sv
// Generic single-port-write RAM with registered read.
module tsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/tsp_datapath.sv
// Datapath of the pairer: queues, stamps, tick counter, compare logic and result registers.
module tsp_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [tsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [tsp_pkg::IN_DATA_W-1:0]      in_data,
  input  logic [tsp_pkg::IN_USER_W-1:0]      in_user,
  input  tsp_pkg::tsp_cmd_t                  cmd,
  output tsp_pkg::tsp_status_t               status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tsp_pkg::OUT_DATA_W-1:0]     out_data,
  output logic [tsp_pkg::OUT_USER_W-1:0]     out_user,
  output logic                               out_last
);
  import tsp_pkg::*;

  localparam int AW      = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int SW      = CW + 1;
  localparam int ENTRY_W = 2 * STAMP_W + TAG_BITS;

  // Configuration registers.
  logic [19:0] sync_tolerance;
  logic [9:0]  hold_ticks;
  logic [4:0]  queue_limit;
  logic        require_match;

  // Latched input beat.
  logic                it_cmd;
  logic                it_src;
  logic [STAMP_W-1:0]  it_stamp;
  logic                it_match;
  logic [TAG_BITS-1:0] it_tag;

  // Queue and time state.
  logic [STAMP_W-1:0] newest [2];
  logic [AW-1:0]      head [2];
  logic [CW-1:0]      cnt [2];
  logic [STAMP_W-1:0] tick_count;

  // Pending result, held back until it is known whether it is the final one.
  logic                    pend_valid;
  logic [2:0]              pend_kind;
  logic [TAG_BITS-1:0]     pend_ptag;
  logic [TAG_BITS-1:0]     pend_stag;
  logic [RESULT_CNT_W-1:0] n_results;

  logic [ENTRY_W-1:0] rd_entry [2];
  logic [ENTRY_W-1:0] wr_entry;
  logic [1:0]         wr_en;
  logic [AW-1:0]      tail;
  logic [SW-1:0]      tail_sum;

  logic [STAMP_W-1:0]  f_stamp [2];
  logic [TAG_BITS-1:0] f_tag [2];
  logic [STAMP_W-1:0]  f_arr [2];

  logic [19:0]        tol_c;
  logic [9:0]         hold_c;
  logic [CW-1:0]      lim;
  logic               p_lt;
  logic [STAMP_W-1:0] diff;
  logic               pair;

  logic                em_valid;
  logic                em_do;
  logic [2:0]          em_kind;
  logic [TAG_BITS-1:0] em_ptag;
  logic [TAG_BITS-1:0] em_stag;
  logic [1:0]          pop;
  logic                out_load;
  logic                out_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_tolerance <= TOL_RESET;
      hold_ticks     <= HOLD_RESET;
      queue_limit    <= QLIM_RESET;
      require_match  <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SYNC_TOLERANCE: sync_tolerance <= cfg_data[19:0];
        REG_HOLD_TICKS:     hold_ticks     <= cfg_data[9:0];
        REG_QUEUE_LIMIT:    queue_limit    <= cfg_data[4:0];
        REG_REQUIRE_MATCH:  require_match  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamped register values.
  always_comb begin
    if (sync_tolerance < TOL_MIN) begin
      tol_c = TOL_MIN;
    end else if (sync_tolerance > TOL_MAX) begin
      tol_c = TOL_MAX;
    end else begin
      tol_c = sync_tolerance;
    end
    if (hold_ticks < HOLD_MIN) begin
      hold_c = HOLD_MIN;
    end else if (hold_ticks > HOLD_MAX) begin
      hold_c = HOLD_MAX;
    end else begin
      hold_c = hold_ticks;
    end
    if (queue_limit < QLIM_MIN) begin
      lim = CW'(2);
    end else if (32'(queue_limit) > QUEUE_DEPTH) begin
      lim = CW'(QUEUE_DEPTH);
    end else begin
      lim = CW'(queue_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_ITEM) begin
      it_cmd   <= in_user[0];
      it_src   <= in_user[1];
      it_stamp <= in_data[STAMP_W-1:0];
      it_match <= in_data[STAMP_W];
      it_tag   <= TAG_BITS'(in_data[STAMP_W+1 +: IN_TAG_W]);
    end
  end

  // Entry layout: stamp in the low bits, then tag, then arrival tick.
  assign wr_entry = {tick_count, it_tag, it_stamp};

  always_comb begin
    tail_sum = SW'(head[it_src]) + SW'(cnt[it_src]);
    if (tail_sum >= SW'(QUEUE_DEPTH)) begin
      tail = AW'(tail_sum - SW'(QUEUE_DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
  end

  for (genvar q = 0; q < 2; q++) begin : g_queue
    assign wr_en[q] = (cmd.op == OP_APPEND) && (it_src == 1'(q));

    tsp_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
    ) u_ram (
      .clk    (clk),
      .wr_en  (wr_en[q]),
      .wr_addr(tail),
      .wr_data(wr_entry),
      .rd_addr(head[q]),
      .rd_data(rd_entry[q])
    );

    assign f_stamp[q] = rd_entry[q][STAMP_W-1:0];
    assign f_tag[q]   = rd_entry[q][STAMP_W +: TAG_BITS];
    assign f_arr[q]   = rd_entry[q][STAMP_W+TAG_BITS +: STAMP_W];

    assign status.aged[q] = (cnt[q] != '0) &&
                            ((tick_count - f_arr[q]) >= STAMP_W'(hold_c));
  end

  // Front comparison: |primary - secondary| against the tolerance.
  always_comb begin
    p_lt = f_stamp[0] < f_stamp[1];
    diff = p_lt ? (f_stamp[1] - f_stamp[0]) : (f_stamp[0] - f_stamp[1]);
    pair = diff <= STAMP_W'(tol_c);
  end

  always_comb begin
    em_valid = 1'b0;
    em_kind  = KIND_REJECT;
    em_ptag  = '0;
    em_stag  = '0;
    pop      = 2'b00;
    case (cmd.op)
      OP_REJECT: begin
        em_valid = 1'b1;
      end
      OP_EVICT: begin
        em_valid = 1'b1;
        em_kind  = it_src ? KIND_SEC_EVICT : KIND_PRI_EVICT;
        if (it_src) begin
          em_stag = f_tag[1];
          pop     = 2'b10;
        end else begin
          em_ptag = f_tag[0];
          pop     = 2'b01;
        end
      end
      OP_MATCH: begin
        em_valid = 1'b1;
        if (pair) begin
          em_kind = KIND_PAIR;
          em_ptag = f_tag[0];
          em_stag = f_tag[1];
          pop     = 2'b11;
        end else if (p_lt) begin
          em_kind = KIND_PRI_OLDER;
          em_ptag = f_tag[0];
          pop     = 2'b01;
        end else begin
          em_kind = KIND_SEC_OLDER;
          em_stag = f_tag[1];
          pop     = 2'b10;
        end
      end
      OP_TIMEOUT: begin
        em_valid = 1'b1;
        em_kind  = cmd.side ? KIND_SEC_TIMEOUT : KIND_PRI_TIMEOUT;
        if (cmd.side) begin
          em_stag = f_tag[1];
          pop     = 2'b10;
        end else begin
          em_ptag = f_tag[0];
          pop     = 2'b01;
        end
      end
      default: ;
    endcase
  end

  assign em_do    = em_valid && (n_results < RESULT_CNT_W'(MAX_RESULTS));
  assign out_room = !out_valid || out_ready;
  assign out_load = pend_valid && (em_do || (cmd.op == OP_FINISH));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < 2; q++) begin
        newest[q] <= '0;
        head[q]   <= '0;
        cnt[q]    <= '0;
      end
      tick_count <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      n_results  <= '0;
    end else begin
      if (cmd.op == OP_TICK) begin
        tick_count <= tick_count + 1'b1;
      end
      if (cmd.op == OP_TAKE) begin
        newest[it_src] <= it_stamp;
      end
      if (cmd.op == OP_APPEND) begin
        cnt[it_src] <= cnt[it_src] + 1'b1;
      end
      for (int q = 0; q < 2; q++) begin
        if (pop[q] && cnt[q] != '0) begin
          head[q] <= (head[q] == AW'(QUEUE_DEPTH - 1)) ? '0 : head[q] + 1'b1;
          cnt[q]  <= cnt[q] - 1'b1;
        end
      end
      if (cmd.op == OP_LOAD_ITEM) begin
        n_results <= '0;
      end else if (em_do) begin
        n_results <= n_results + 1'b1;
      end
      if (em_do) begin
        pend_valid <= 1'b1;
      end else if (cmd.op == OP_FINISH) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (em_do) begin
      pend_kind <= em_kind;
      pend_ptag <= em_ptag;
      pend_stag <= em_stag;
    end
    if (out_load) begin
      out_user <= pend_kind;
      out_data <= {OUT_TAG_W'(pend_stag), OUT_TAG_W'(pend_ptag)};
      out_last <= (cmd.op == OP_FINISH);
    end
  end

  assign status.is_tick   = it_cmd;
  assign status.rejected  = (it_stamp == '0) || (it_stamp <= newest[it_src]) ||
                            (require_match && !it_match);
  assign status.evict_due = cnt[it_src] >= lim;
  assign status.both_nz   = (cnt[0] != '0) && (cnt[1] != '0);
  assign status.emit_ok   = !pend_valid || out_room;

endmodule

FILE: sv/tsp_ctrl.sv
// Controller state machine of the pairer: sequences the steps of one input beat.
module tsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tsp_pkg::tsp_status_t status,
  output tsp_pkg::tsp_cmd_t    cmd
);
  import tsp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_START    = 10'b0000000010,
    S_EVICT_LD = 10'b0000000100,
    S_EVICT    = 10'b0000001000,
    S_APPEND   = 10'b0000010000,
    S_MATCH_LD = 10'b0000100000,
    S_MATCH    = 10'b0001000000,
    S_TO_LD    = 10'b0010000000,
    S_TIMEOUT  = 10'b0100000000,
    S_FINISH   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   side;
  logic   side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
    end
  end

  // The *_LD states wait for the registered read of the queue memories to present the new fronts.
  always_comb begin
    state_next = state;
    side_next  = side;
    cmd.op     = OP_NONE;
    cmd.side   = side;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD_ITEM;
          state_next = S_START;
        end
      end
      S_START: begin
        if (status.is_tick) begin
          cmd.op     = OP_TICK;
          side_next  = 1'b0;
          state_next = S_MATCH_LD;
        end else if (status.rejected) begin
          if (status.emit_ok) begin
            cmd.op     = OP_REJECT;
            state_next = S_FINISH;
          end
        end else begin
          cmd.op     = OP_TAKE;
          state_next = S_EVICT_LD;
        end
      end
      S_EVICT_LD: state_next = S_EVICT;
      S_EVICT: begin
        if (status.evict_due) begin
          if (status.emit_ok) begin
            cmd.op     = OP_EVICT;
            state_next = S_EVICT_LD;
          end
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.op     = OP_APPEND;
        state_next = S_MATCH_LD;
      end
      S_MATCH_LD: state_next = S_MATCH;
      S_MATCH: begin
        if (status.both_nz) begin
          if (status.emit_ok) begin
            cmd.op     = OP_MATCH;
            state_next = S_MATCH_LD;
          end
        end else if (status.is_tick) begin
          state_next = S_TO_LD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_TO_LD: state_next = S_TIMEOUT;
      S_TIMEOUT: begin
        if (status.aged[side]) begin
          if (status.emit_ok) begin
            cmd.op     = OP_TIMEOUT;
            state_next = S_TO_LD;
          end
        end else if (!side) begin
          side_next  = 1'b1;
          state_next = S_TO_LD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.emit_ok) begin
          cmd.op     = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: sv/two_stream_timestamp_pairer.sv
// Top level of the two-stream timestamp pairer.
//
// Input stream (s_axis): one beat is either a frame arrival or a time tick.
// A frame is rejected, or queued under its source and matched against the
// other queue's front; a tick ages the fronts and issues lone ones that have
// waited the hold time. Output stream (m_axis): one beat per issued result,
// a pair or a single frame, with tlast on the final result of an input beat.
// An input beat may cause no result at all.
// Configuration (cfg_*) is to be written only while the block is idle; the
// block itself does not enforce this. The block handles one input beat at a
// time and takes a new one only after the previous one is finished. Every
// eviction, match or timeout pops a queue front and is followed by a *_LD
// reload state, as the queue memories have a registered read.
// A result leaves one step after it is formed, since the last flag is only
// known once the next step is decided.
// Reset clears the queues, the newest stamps and the tick counter, and loads
// the register defaults. When the receiver stalls, the block finishes the
// step in flight and then waits with the next result held.
module two_stream_timestamp_pairer #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [tsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // stamp[31:0], frame_matches[32], tag[48:33], zero pad
  input  logic [tsp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // cmd[0], source[1]
  input  logic [tsp_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // primary_tag[15:0], secondary_tag[31:16]
  output logic [tsp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // kind[2:0]
  output logic [tsp_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  output logic                            m_axis_tlast
);
  import tsp_pkg::*;

  tsp_cmd_t    cmd;
  tsp_status_t status;

  tsp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  tsp_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .cmd      (cmd),
    .status   (status),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser),
    .out_last (m_axis_tlast)
  );

endmodule

FILE: sv/tsp_checker.sv
// Port-level checker for the pairer and its bind to the top level.
module tsp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tsp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [tsp_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  input logic                            m_axis_tlast
);
  import tsp_pkg::*;

  // A stalled output beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // No new input is taken while results of the previous one are still coming.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready while results of an item are pending");

  // A rejection is the only result of its beat and carries no tags.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_REJECT |->
      m_axis_tlast && m_axis_tdata == '0)
    else $error("rejection result malformed");

  // A lone primary frame has no secondary tag.
  a_pri_alone: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_PRI_OLDER ||
      m_axis_tuser == KIND_PRI_TIMEOUT || m_axis_tuser == KIND_PRI_EVICT) |->
      m_axis_tdata[31:16] == '0)
    else $error("lone primary result carries a secondary tag");

  // A lone secondary frame has no primary tag.
  a_sec_alone: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_SEC_OLDER ||
      m_axis_tuser == KIND_SEC_TIMEOUT || m_axis_tuser == KIND_SEC_EVICT) |->
      m_axis_tdata[15:0] == '0)
    else $error("lone secondary result carries a primary tag");

endmodule

bind two_stream_timestamp_pairer tsp_checker u_tsp_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

FILE: sim/tb_two_stream_timestamp_pairer.sv
// Self-checking testbench of the two-stream timestamp pairer with a behavioral predictor.
module tb_two_stream_timestamp_pairer;
  import tsp_pkg::*;

  localparam int   QDEPTH         = 16;
  localparam int   MAX_GAP        = 19;
  localparam int   SETTLE_CYCLES  = 40;
  localparam int   PHASE_ITEMS    = 34;
  localparam int   TIMEOUT_CYCLES = 1000000;
  localparam logic CMD_FRAME      = 1'b0;
  localparam logic CMD_TICK       = 1'b1;
  localparam logic SRC_PRIMARY    = 1'b0;
  localparam logic SRC_SECONDARY  = 1'b1;

  typedef struct packed {
    logic [2:0]           kind;
    logic [OUT_TAG_W-1:0] primary_tag;
    logic [OUT_TAG_W-1:0] secondary_tag;
    logic                 last;
  } issue_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_wr_en     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]   s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [OUT_USER_W-1:0]  m_axis_tuser;
  logic                   m_axis_tlast;

  // Predictor state: one ring buffer per source.
  logic [31:0]          q_stamp   [2][QDEPTH];
  logic [IN_TAG_W-1:0]  q_tag     [2][QDEPTH];
  logic [31:0]          q_arrival [2][QDEPTH];
  int unsigned          q_head    [2];
  int unsigned          q_count   [2];
  logic [31:0]          newest_stamp [2];
  logic [31:0]          tick_count;
  logic [19:0]          tolerance_reg;
  logic [9:0]           hold_reg;
  logic [4:0]           limit_reg;
  logic                 match_reg;

  issue_t issues_due[$];
  issue_t beat_issues[$];
  int     errors       = 0;
  int     tx_max_gap   = MAX_GAP;
  int     rx_max_stall = MAX_GAP;
  int     rx_hold_off  = 0;
  logic [31:0] clock_us = 32'd1000000;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  two_stream_timestamp_pairer i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------- predictor

  task automatic note_issue(input logic [2:0] kind, input logic [15:0] ptag,
                            input logic [15:0] stag);
    issue_t item;
    item = '{kind, ptag, stag, 1'b0};
    if (beat_issues.size() < MAX_RESULTS) beat_issues.insert(beat_issues.size(), item);
  endtask

  task automatic drop_front(input int s);
    q_head[s] = (q_head[s] + 1) % QDEPTH;
    q_count[s]--;
  endtask

  task automatic issue_front(input int s, input logic [2:0] kind);
    logic [15:0] t;
    t = q_tag[s][q_head[s]];
    if (s == 1) note_issue(kind, '0, t);
    else note_issue(kind, t, '0);
    drop_front(s);
  endtask

  task automatic match_fronts(input bit aging);
    longint      d;
    longint      ad;
    longint      tol;
    logic [31:0] hold;
    logic [31:0] age;
    tol  = longint'(tolerance_reg < TOL_MIN ? TOL_MIN :
                    (tolerance_reg > TOL_MAX ? TOL_MAX : tolerance_reg));
    hold = 32'(hold_reg < HOLD_MIN ? HOLD_MIN : (hold_reg > HOLD_MAX ? HOLD_MAX : hold_reg));
    while (q_count[0] != 0 && q_count[1] != 0) begin
      d  = longint'({32'b0, q_stamp[0][q_head[0]]}) - longint'({32'b0, q_stamp[1][q_head[1]]});
      ad = d < 0 ? -d : d;
      if (ad <= tol) begin
        note_issue(KIND_PAIR, q_tag[0][q_head[0]], q_tag[1][q_head[1]]);
        drop_front(0);
        drop_front(1);
      end else if (d < 0) begin
        issue_front(0, KIND_PRI_OLDER);
      end else begin
        issue_front(1, KIND_SEC_OLDER);
      end
    end
    if (aging) begin
      for (int s = 0; s < 2; s++) begin
        while (q_count[s] != 0) begin
          // Age is taken modulo 2^32, like the tick counter itself.
          age = tick_count - q_arrival[s][q_head[s]];
          if (age < hold) break;
          issue_front(s, s ? KIND_SEC_TIMEOUT : KIND_PRI_TIMEOUT);
        end
      end
    end
  endtask

  task automatic pair_frames(input logic cmd, input logic src, input logic [31:0] stamp,
                             input logic id_ok, input logic [15:0] tag);
    int          s;
    int unsigned lim;
    int unsigned slot;
    beat_issues.delete();
    s = int'(src);
    if (cmd == CMD_TICK) begin
      tick_count++;
      match_fronts(1'b1);
    end else if (stamp == 0 || stamp <= newest_stamp[s] || (match_reg && !id_ok)) begin
      note_issue(KIND_REJECT, '0, '0);
    end else begin
      lim = 32'(limit_reg < QLIM_MIN ? QLIM_MIN : (limit_reg > QDEPTH ? QDEPTH : limit_reg));
      newest_stamp[s] = stamp;
      while (q_count[s] >= lim) issue_front(s, s ? KIND_SEC_EVICT : KIND_PRI_EVICT);
      slot = (q_head[s] + q_count[s]) % QDEPTH;
      q_stamp[s][slot]   = stamp;
      q_tag[s][slot]     = tag;
      q_arrival[s][slot] = tick_count;
      q_count[s]++;
      match_fronts(1'b0);
    end
    if (beat_issues.size() > 0) beat_issues[$].last = 1'b1;
    foreach (beat_issues[i]) issues_due.insert(issues_due.size(), beat_issues[i]);
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic send_beat(input logic cmd, input logic src, input logic [31:0] stamp,
                           input logic id_ok, input logic [15:0] tag);
    int gap;
    gap = tx_max_gap > 0 ? $urandom_range(tx_max_gap) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, tag, id_ok, stamp};
    s_axis_tuser  <= {src, cmd};
    do @(posedge clk); while (!s_axis_tready);
    pair_frames(cmd, src, stamp, id_ok, tag);
  endtask

  task automatic send_frame(input logic src, input logic [31:0] stamp, input logic id_ok,
                            input logic [15:0] tag);
    send_beat(CMD_FRAME, src, stamp, id_ok, tag);
  endtask

  // Source, stamp, match flag and tag of a tick are don't-care, so they carry noise.
  task automatic send_tick();
    send_beat(CMD_TICK, 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
              16'($urandom_range(16'hFFFF)));
  endtask

  task automatic send_random_frame();
    int          s;
    logic [31:0] stamp;
    s = $urandom_range(1);
    clock_us += $urandom_range(60000);
    stamp = clock_us + $urandom_range(60000);
    if (stamp <= newest_stamp[s]) stamp = newest_stamp[s] + 1 + $urandom_range(2000);
    send_frame(1'(s), stamp, match_reg ? 1'b1 : 1'($urandom_range(1)),
               16'($urandom_range(16'hFFFF)));
  endtask

  task automatic send_noise_frame();
    int          s;
    logic [31:0] stamp;
    logic        id_ok;
    s = $urandom_range(1);
    id_ok = 1'b1;
    case ($urandom_range(2))
      0: stamp = '0;
      1: stamp = $urandom_range(newest_stamp[s]);
      default: begin
        stamp = newest_stamp[s] + 1 + $urandom_range(5000);
        id_ok = 1'b0;
      end
    endcase
    send_frame(1'(s), stamp, id_ok, 16'($urandom_range(16'hFFFF)));
  endtask

  task automatic send_random_item();
    int r;
    r = $urandom_range(99);
    if (r < 15) send_tick();
    else if (r < 25) send_noise_frame();
    else send_random_frame();
  endtask

  // Waits until every expected result is out, then lets a frame that gives no
  // result finish inside the block.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (issues_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (index)
      REG_SYNC_TOLERANCE: tolerance_reg = value;
      REG_HOLD_TICKS:     hold_reg      = value[9:0];
      REG_QUEUE_LIMIT:    limit_reg     = value[4:0];
      REG_REQUIRE_MATCH:  match_reg     = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [19:0] tol, input logic [9:0] hold,
                           input logic [4:0] qlim, input logic req);
    settle();
    write_reg(REG_SYNC_TOLERANCE, tol);
    write_reg(REG_HOLD_TICKS, 20'(hold));
    write_reg(REG_QUEUE_LIMIT, 20'(qlim));
    write_reg(REG_REQUIRE_MATCH, 20'(req));
  endtask

  // ---------------------------------------------------------------- checker

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_issue(input issue_t got);
    issue_t want;
    if (issues_due.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0d tags %h/%h last %b",
               $time, got.kind, got.primary_tag, got.secondary_tag, got.last);
      errors++;
    end else begin
      want = issues_due[0];
      issues_due.delete(0);
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("primary_tag", 32'(want.primary_tag), 32'(got.primary_tag));
      compare_field("secondary_tag", 32'(want.secondary_tag), 32'(got.secondary_tag));
      compare_field("last", 32'(want.last), 32'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      check_issue('{m_axis_tuser[2:0], m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast});
  end

  // Result side: a random stall before every beat, or a long hold-off on request.
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_off > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_off) @(posedge clk);
        rx_hold_off = 0;
      end else begin
        stall = rx_max_stall > 0 ? $urandom_range(rx_max_stall) : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_rejects();
    send_frame(SRC_PRIMARY, 32'd0, 1'b1, 16'h1234);
    send_frame(SRC_PRIMARY, 32'd1000, 1'b0, 16'h4321);
    send_tick();
  endtask

  // Default tolerance: an exact-tolerance pair, both older cases, stale stamps.
  task automatic test_pairing();
    send_frame(SRC_PRIMARY, 32'd1000, 1'b1, 16'hFFFF);
    send_frame(SRC_SECONDARY, 32'd81000, 1'b1, 16'h0000);
    send_frame(SRC_PRIMARY, 32'd200000, 1'b1, 16'h00FF);
    send_frame(SRC_SECONDARY, 32'd280001, 1'b1, 16'hFF00);
    send_frame(SRC_PRIMARY, 32'd400000, 1'b1, 16'h5A5A);
    send_frame(SRC_PRIMARY, 32'd400000, 1'b1, 16'hA5A5);
    send_frame(SRC_SECONDARY, 32'd400000, 1'b1, 16'h0F0F);
    send_frame(SRC_SECONDARY, 32'd300000, 1'b1, 16'hF0F0);
  endtask

  task automatic test_timeout_and_evict();
    configure(20'd5000, 10'd2, 5'd2, 1'b0);
    send_frame(SRC_PRIMARY, 32'd500000, 1'b0, 16'h1111);
    repeat (2) send_tick();
    send_frame(SRC_SECONDARY, 32'd600000, 1'b1, 16'h2222);
    repeat (2) send_tick();
    send_frame(SRC_PRIMARY, 32'd700000, 1'b1, 16'h3333);
    send_frame(SRC_PRIMARY, 32'd700001, 1'b1, 16'h4444);
    send_frame(SRC_PRIMARY, 32'd700002, 1'b1, 16'h5555);
    send_frame(SRC_SECONDARY, 32'd800000, 1'b1, 16'h6666);
    send_frame(SRC_SECONDARY, 32'd800001, 1'b1, 16'h7777);
    send_frame(SRC_SECONDARY, 32'd800002, 1'b1, 16'h8888);
    repeat (2) send_tick();
  endtask

  // Fill the primary queue, then lower the limit so one arrival drains it.
  task automatic test_lowered_limit();
    configure(20'd1000000, 10'd1000, 5'd16, 1'b1);
    send_frame(SRC_PRIMARY, newest_stamp[0] + 32'd2000000, 1'b1,
               16'($urandom_range(16'hFFFF)));
    repeat (16) send_frame(SRC_PRIMARY, newest_stamp[0] + 32'd1000, 1'b1,
                           16'($urandom_range(16'hFFFF)));
    settle();
    write_reg(REG_QUEUE_LIMIT, 20'd2);
    send_frame(SRC_PRIMARY, newest_stamp[0] + 32'd1000, 1'b1, 16'($urandom_range(16'hFFFF)));
    send_frame(SRC_SECONDARY, newest_stamp[0], 1'b1, 16'($urandom_range(16'hFFFF)));
    clock_us = newest_stamp[0];
  endtask

  task automatic test_random_phase(input logic [19:0] tol, input logic [9:0] hold,
                                   input logic [4:0] qlim, input logic req);
    configure(tol, hold, qlim, req);
    repeat (PHASE_ITEMS) send_random_item();
  endtask

  task automatic test_no_idle();
    settle();
    tx_max_gap   = 0;
    rx_max_stall = 0;
    test_random_phase(20'd80000, 10'd3, 5'd6, 1'b1);
    tx_max_gap   = MAX_GAP;
    rx_max_stall = MAX_GAP;
  endtask

  // The receiver holds off while frames keep coming back to back.
  task automatic test_backpressure();
    tx_max_gap  = 0;
    rx_hold_off = 300;
    repeat (12) send_random_frame();
    tx_max_gap  = MAX_GAP;
  endtask

  task automatic test_stamp_ceiling();
    send_frame(SRC_PRIMARY, 32'hFFFF_FFFE, 1'b1, 16'($urandom_range(16'hFFFF)));
    send_frame(SRC_SECONDARY, 32'hFFFF_FFFF, 1'b1, 16'($urandom_range(16'hFFFF)));
    send_frame(SRC_PRIMARY, 32'hFFFF_FFFF, 1'b1, 16'($urandom_range(16'hFFFF)));
    send_frame(SRC_SECONDARY, 32'hFFFF_FFFF, 1'b1, 16'($urandom_range(16'hFFFF)));
    send_tick();
  endtask

  initial begin
    for (int s = 0; s < 2; s++) begin
      q_head[s]       = 0;
      q_count[s]      = 0;
      newest_stamp[s] = '0;
    end
    tick_count    = '0;
    tolerance_reg = TOL_RESET;
    hold_reg      = HOLD_RESET;
    limit_reg     = QLIM_RESET;
    match_reg     = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_rejects();
    test_pairing();
    test_timeout_and_evict();
    test_lowered_limit();
    test_random_phase(20'd0, 10'd0, 5'd0, 1'b0);
    test_random_phase(20'd5000, 10'd1, 5'd2, 1'b1);
    test_random_phase(20'd1000000, 10'd4, 5'd16, 1'b0);
    test_random_phase(20'hFFFFF, 10'h3FF, 5'h1F, 1'b1);
    test_random_phase(20'($urandom_range(200000, 5000)), 10'($urandom_range(8, 1)),
                      5'($urandom_range(16, 2)), 1'($urandom_range(1)));
    test_no_idle();
    test_backpressure();
    test_stamp_ceiling();
    settle();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("FAILURE");
    $finish;
  end

endmodule
